// ----- hw/rtl/kvd_pkg.sv -----
// Package for the katakana voicing decomposer: channel words, byte codes,
// and the voiced/semi-voiced kana table. No dependencies.
package kvd_pkg;

  localparam logic [7:0] LEAD_BYTE    = 8'he3;
  localparam logic [7:0] MARK_MID     = 8'h82;
  localparam logic [7:0] COMB_VOICED  = 8'h99;
  localparam logic [7:0] COMB_SEMI    = 8'h9a;
  localparam logic [7:0] SPACE_VOICED = 8'h9b;
  localparam logic [7:0] SPACE_SEMI   = 8'h9c;
  localparam int         MAX_BYTES    = 6;
  localparam int         TABLE_SIZE   = 25;

  typedef logic [2:0] cnt_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_MID  = 2'd2,
    PH_RSVD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       truncated;
  } out_word_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    cnt_t                      count;
    logic                      eos;
    logic                      trunc;
  } burst_t;

  typedef struct packed {
    logic       hit;
    logic       semi;
    logic [7:0] base_mid;
    logic [7:0] base_low;
  } kana_hit_t;

  typedef struct packed {
    logic [7:0] v_mid;
    logic [7:0] v_low;
    logic       has_semi;
    logic [7:0] s_low;
    logic [7:0] b_mid;
    logic [7:0] b_low;
  } kana_entry_t;

  localparam kana_entry_t KANA_TABLE [TABLE_SIZE] = '{
    '{8'h83, 8'hb4, 1'b0, 8'h00, 8'h82, 8'ha6},
    '{8'h82, 8'hac, 1'b0, 8'h00, 8'h82, 8'hab},
    '{8'h82, 8'hae, 1'b0, 8'h00, 8'h82, 8'had},
    '{8'h82, 8'hb0, 1'b0, 8'h00, 8'h82, 8'haf},
    '{8'h82, 8'hb2, 1'b0, 8'h00, 8'h82, 8'hb1},
    '{8'h82, 8'hb4, 1'b0, 8'h00, 8'h82, 8'hb3},
    '{8'h82, 8'hb6, 1'b0, 8'h00, 8'h82, 8'hb5},
    '{8'h82, 8'hb8, 1'b0, 8'h00, 8'h82, 8'hb7},
    '{8'h82, 8'hba, 1'b0, 8'h00, 8'h82, 8'hb9},
    '{8'h82, 8'hbc, 1'b0, 8'h00, 8'h82, 8'hbb},
    '{8'h82, 8'hbe, 1'b0, 8'h00, 8'h82, 8'hbd},
    '{8'h83, 8'h80, 1'b0, 8'h00, 8'h82, 8'hbf},
    '{8'h83, 8'h82, 1'b0, 8'h00, 8'h83, 8'h81},
    '{8'h83, 8'h85, 1'b0, 8'h00, 8'h83, 8'h84},
    '{8'h83, 8'h87, 1'b0, 8'h00, 8'h83, 8'h86},
    '{8'h83, 8'h89, 1'b0, 8'h00, 8'h83, 8'h88},
    '{8'h83, 8'h90, 1'b1, 8'h91, 8'h83, 8'h8f},
    '{8'h83, 8'h93, 1'b1, 8'h94, 8'h83, 8'h92},
    '{8'h83, 8'h96, 1'b1, 8'h97, 8'h83, 8'h95},
    '{8'h83, 8'h99, 1'b1, 8'h9a, 8'h83, 8'h98},
    '{8'h83, 8'h9c, 1'b1, 8'h9d, 8'h83, 8'h9b},
    '{8'h83, 8'hb7, 1'b0, 8'h00, 8'h83, 8'haf},
    '{8'h83, 8'hb8, 1'b0, 8'h00, 8'h83, 8'hb0},
    '{8'h83, 8'hb9, 1'b0, 8'h00, 8'h83, 8'hb1},
    '{8'h83, 8'hba, 1'b0, 8'h00, 8'h83, 8'hb2}
  };

  // first matching entry wins
  function automatic kana_hit_t kana_lookup(input logic [7:0] mid, input logic [7:0] low);
    kana_hit_t r;
    logic      v;
    logic      s;
    r = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      v = (KANA_TABLE[i].v_mid == mid) && (KANA_TABLE[i].v_low == low);
      s = KANA_TABLE[i].has_semi && (KANA_TABLE[i].v_mid == mid) &&
          (KANA_TABLE[i].s_low == low);
      if (v || s) begin
        r.hit      = 1'b1;
        r.semi     = !v;
        r.base_mid = KANA_TABLE[i].b_mid;
        r.base_low = KANA_TABLE[i].b_low;
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/kvd_expand.sv -----
// Combinational expansion of one input word into a burst of output bytes
// and the next sequence state. Depends on kvd_pkg.
module kvd_expand import kvd_pkg::*; (
  input  phase_t     phase,
  input  logic [7:0] middle,
  input  in_word_t   word,
  output burst_t     burst,
  output phase_t     phase_nxt,
  output logic [7:0] middle_nxt
);

  kana_hit_t hit;

  assign hit = kana_lookup(middle, word.in_byte);

  always_comb begin
    burst      = '0;
    burst.eos  = word.end_of_string;
    phase_nxt  = PH_IDLE;
    middle_nxt = middle;
    case (phase)
      PH_LEAD: begin
        if (word.end_of_string) begin
          burst.count = 3'd1;
          burst.trunc = 1'b1;
        end else begin
          middle_nxt = word.in_byte;
          phase_nxt  = PH_MID;
        end
      end
      PH_MID: begin
        burst.bytes[0] = LEAD_BYTE;
        burst.bytes[1] = middle;
        burst.bytes[2] = word.in_byte;
        burst.count    = 3'd3;
        if (middle == MARK_MID &&
            (word.in_byte == COMB_VOICED || word.in_byte == COMB_SEMI)) begin
          burst.bytes[2] = word.in_byte + 8'd2;
        end else if (hit.hit) begin
          burst.bytes[1] = hit.base_mid;
          burst.bytes[2] = hit.base_low;
          burst.bytes[3] = LEAD_BYTE;
          burst.bytes[4] = MARK_MID;
          burst.bytes[5] = hit.semi ? SPACE_SEMI : SPACE_VOICED;
          burst.count    = 3'd6;
        end
      end
      default: begin
        if (word.in_byte == LEAD_BYTE) begin
          if (word.end_of_string) begin
            burst.count = 3'd1;
            burst.trunc = 1'b1;
          end else begin
            phase_nxt = PH_LEAD;
          end
        end else begin
          burst.bytes[0] = word.in_byte;
          burst.count    = 3'd1;
        end
      end
    endcase
  end

endmodule

// ----- hw/rtl/katakana_voicing_decomposer_unit.sv -----
// Top level of the katakana voicing decomposer: input register, expansion, burst
// register: one byte per cycle unless stalled. Depends on kvd_pkg, kvd_expand.
//
//   port group   dir   payload       handshake
//   in_          in    in_word_t     in_valid / in_stall
//   out_         out   out_word_t    out_valid / out_stall
//
// Each input word enters a holding register, then expands in one step into a
// burst of zero to six bytes; the burst register sends one byte per cycle
// while out_stall is low.
// A new word is taken while the final byte of the previous burst goes out.
// Reset clears the sequence state and both valid flags.
module katakana_voicing_decomposer_unit import kvd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic       a_valid_r, a_valid_nxt;
  in_word_t   a_word_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] middle_r, middle_nxt;
  burst_t     burst_r, burst_nxt;
  cnt_t       idx_r;
  logic       out_fire, burst_end, b_free, a_move, in_acc;

  kvd_expand u_expand (
    .phase      (phase_r),
    .middle     (middle_r),
    .word       (a_word_r),
    .burst      (burst_nxt),
    .phase_nxt  (phase_nxt),
    .middle_nxt (middle_nxt)
  );

  assign out_valid = burst_r.count != 3'd0;
  assign out_fire  = out_valid && !out_stall;
  assign burst_end = out_fire && (idx_r == burst_r.count - 3'd1);
  assign b_free    = !out_valid || burst_end;
  assign a_move    = a_valid_r && b_free;
  assign in_stall  = a_valid_r && !b_free;
  assign in_acc    = in_valid && !in_stall;

  assign a_valid_nxt = in_acc ? 1'b1 : (a_move ? 1'b0 : a_valid_r);

  assign out_word.out_byte  = burst_r.bytes[idx_r];
  assign out_word.last_out  = burst_r.eos && (idx_r == burst_r.count - 3'd1);
  assign out_word.truncated = burst_r.trunc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      phase_r       <= PH_IDLE;
      middle_r      <= 8'h00;
      burst_r.count <= 3'd0;
      idx_r         <= 3'd0;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (in_acc) begin
        a_word_r <= in_word;
      end
      if (a_move) begin
        phase_r  <= phase_nxt;
        middle_r <= middle_nxt;
        burst_r  <= burst_nxt;
        idx_r    <= 3'd0;
      end else if (burst_end) begin
        burst_r.count <= 3'd0;
        idx_r         <= 3'd0;
      end else if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for katakana_voicing_decomposer_unit: streams bytes and
// predicts each decomposed output word. Depends on kvd_pkg and the unit's RTL.
// Sender bursts and gaps at random; receiver stalls on a shifting pattern.
module tb_top import kvd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 400000;
  localparam int DRAIN_TICKS = 20;

  localparam logic [7:0] VOICED_MID [25] = '{
    8'h83, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82,
    8'h82, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83,
    8'h83, 8'h83, 8'h83, 8'h83, 8'h83};
  localparam logic [7:0] VOICED_LOW [25] = '{
    8'hb4, 8'hac, 8'hae, 8'hb0, 8'hb2, 8'hb4, 8'hb6, 8'hb8, 8'hba, 8'hbc,
    8'hbe, 8'h80, 8'h82, 8'h85, 8'h87, 8'h89, 8'h90, 8'h93, 8'h96, 8'h99,
    8'h9c, 8'hb7, 8'hb8, 8'hb9, 8'hba};
  localparam logic [7:0] SEMI_LOW [25] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h91, 8'h94, 8'h97, 8'h9a,
    8'h9d, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic SEMI_OK [25] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam logic [7:0] PLAIN_MID [25] = '{
    8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82, 8'h82,
    8'h82, 8'h82, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83, 8'h83,
    8'h83, 8'h83, 8'h83, 8'h83, 8'h83};
  localparam logic [7:0] PLAIN_LOW [25] = '{
    8'ha6, 8'hab, 8'had, 8'haf, 8'hb1, 8'hb3, 8'hb5, 8'hb7, 8'hb9, 8'hbb,
    8'hbd, 8'hbf, 8'h81, 8'h84, 8'h86, 8'h88, 8'h8f, 8'h92, 8'h95, 8'h98,
    8'h9b, 8'haf, 8'hb0, 8'hb1, 8'hb2};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  phase_t     seq_phase = PH_IDLE;
  logic [7:0] held_mid = 8'h00;
  out_word_t  expected_words [$];
  int         mismatches = 0;
  int         burst_left = 0;
  int         stall_pct = 0;
  logic [5:0] stall_tick = '0;

  katakana_voicing_decomposer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  function automatic void expect_word(logic [7:0] b, logic last, logic trunc);
    expected_words.push_back({b, last, trunc});
  endfunction

  function automatic void decompose_word(in_word_t w);
    logic [7:0] seq_bytes [6];
    int         n;
    logic       found;
    logic       eos;
    logic [7:0] b;
    b   = w.in_byte;
    eos = w.end_of_string;
    if (seq_phase == PH_LEAD) begin
      if (eos) begin
        seq_phase = PH_IDLE;
        expect_word(8'h00, 1'b1, 1'b1);
      end else begin
        held_mid  = b;
        seq_phase = PH_MID;
      end
    end else if (seq_phase != PH_MID) begin
      if (b == LEAD_BYTE && eos) begin
        seq_phase = PH_IDLE;
        expect_word(8'h00, 1'b1, 1'b1);
      end else if (b == LEAD_BYTE) begin
        seq_phase = PH_LEAD;
      end else begin
        seq_phase = PH_IDLE;
        expect_word(b, eos, 1'b0);
      end
    end else begin
      seq_phase    = PH_IDLE;
      seq_bytes[0] = LEAD_BYTE;
      seq_bytes[1] = held_mid;
      seq_bytes[2] = b;
      n            = 3;
      found        = 1'b0;
      if (held_mid == MARK_MID && (b == COMB_VOICED || b == COMB_SEMI)) begin
        seq_bytes[2] = b + 8'd2;
      end else begin
        for (int i = 0; i < 25; i++) begin
          if (!found && VOICED_MID[i] == held_mid &&
              (VOICED_LOW[i] == b || (SEMI_OK[i] && SEMI_LOW[i] == b))) begin
            found        = 1'b1;
            seq_bytes[1] = PLAIN_MID[i];
            seq_bytes[2] = PLAIN_LOW[i];
            seq_bytes[3] = LEAD_BYTE;
            seq_bytes[4] = MARK_MID;
            seq_bytes[5] = (VOICED_LOW[i] == b) ? SPACE_VOICED : SPACE_SEMI;
            n            = 6;
          end
        end
      end
      for (int i = 0; i < n; i++)
        expect_word(seq_bytes[i], eos && i == n - 1, 1'b0);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      decompose_word(in_word);
  end

  always @(posedge clk) begin : check_result
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_word));
      end else begin
        want = expected_words.pop_front();
        if (out_word.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_word.out_byte,
                                    want.out_byte));
        if (out_word.last_out !== want.last_out)
          report_mismatch($sformatf("last_out %b, want %b", out_word.last_out,
                                    want.last_out));
        if (out_word.truncated !== want.truncated)
          report_mismatch($sformatf("truncated %b, want %b", out_word.truncated,
                                    want.truncated));
      end
    end
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 20;
        2:       stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= {b, eos};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_triple(input logic [7:0] mid, input logic [7:0] low,
                             input logic eos);
    send_word(LEAD_BYTE, 1'b0);
    send_word(mid, 1'b0);
    send_word(low, eos);
  endtask

  task automatic test_plain_bytes();
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h7f, 1'b1);
  endtask

  task automatic test_combining_marks();
    send_triple(MARK_MID, COMB_VOICED, 1'b0);
    send_triple(MARK_MID, COMB_SEMI, 1'b1);
  endtask

  task automatic test_table_kana();
    send_triple(VOICED_MID[0], VOICED_LOW[0], 1'b0);
    send_triple(VOICED_MID[19], SEMI_LOW[19], 1'b1);
  endtask

  task automatic test_truncation();
    send_word(LEAD_BYTE, 1'b1);
    send_word(LEAD_BYTE, 1'b0);
    send_word(MARK_MID, 1'b1);
  endtask

  task automatic test_lead_inside_sequence();
    send_triple(LEAD_BYTE, LEAD_BYTE, 1'b1);
  endtask

  task automatic test_random_strings();
    logic [7:0] piece [3];
    int         len;
    int         idx;
    int         words;
    logic       close;
    words = 0;
    while (words < 140) begin
      idx      = $urandom_range(0, 24);
      close    = ($urandom_range(0, 3) == 0);
      piece[0] = LEAD_BYTE;
      len      = 3;
      case ($urandom_range(0, 9))
        0, 1: begin
          piece[0] = 8'($urandom_range(0, 255));
          len      = 1;
        end
        2, 3: begin
          piece[1] = VOICED_MID[idx];
          piece[2] = VOICED_LOW[idx];
        end
        4: begin
          idx      = $urandom_range(16, 20);
          piece[1] = VOICED_MID[idx];
          piece[2] = SEMI_LOW[idx];
        end
        5: begin
          piece[1] = MARK_MID;
          piece[2] = $urandom_range(0, 1) ? COMB_SEMI : COMB_VOICED;
        end
        6: begin
          piece[1] = 8'($urandom_range(0, 255));
          piece[2] = 8'($urandom_range(0, 255));
        end
        7: begin
          piece[1] = 8'($urandom_range(0, 255));
          len      = $urandom_range(1, 2);
          close    = 1'b1;
        end
        default: begin
          piece[1] = VOICED_MID[idx];
          piece[2] = VOICED_LOW[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
      endcase
      for (int i = 0; i < len; i++)
        send_word(piece[i], close && i == len - 1);
      words += len;
    end
    send_word(8'h0a, 1'b1);
  endtask

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_combining_marks();
    test_table_kana();
    test_truncation();
    test_lead_inside_sequence();
    test_random_strings();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
